@@ rtl/core/radical_inverse_sequence_assert.svh @@
// assertion macros for the radical inverse sequence block
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef RADICAL_INVERSE_SEQUENCE_ASSERT_SVH
`define RADICAL_INVERSE_SEQUENCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rdi_pkg.sv @@
// shared constants and helpers for the radical inverse sequence block
// no dependencies
package rdi_pkg;

  localparam int SEQ_W     = 16;  // seq_index port width
  localparam int FRAC_W    = 24;  // fraction port width
  localparam int RADIX_W   = 9;   // radix register width
  localparam int DIGIT_W   = 8;   // one digit, always below the base

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd2;

  // bases outside 2..256 saturate to the nearest end
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
    logic [RADIX_W-1:0] res;
    if (v < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/radical_inverse_sequence.sv @@
// channel   | handshake              | payload
// ----------+------------------------+-------------------------
// cfg       | cfg_valid / cfg_ready  | radix [8:0]
// input     | in_valid / in_ready    | seq_index [15:0]
// output    | out_valid / out_ready  | fraction [23:0]
//
// each item runs the bit-serial digit divider once per digit of the index in the current
// base (not at all for index 0), each digit followed by an accumulate step, and then the
// bit-serial quotient loop that produces the fraction bits.
// reset sets the base to 2; there is no clearing pass, cfg is always ready.
// a finished result sits in the output register while the next item is taken;
// if it is still held when the next result is due, the block waits there.
// van der corput radical inverse, digit serial datapath
// depends on rdi_pkg and radical_inverse_sequence_assert.svh
`include "radical_inverse_sequence_assert.svh"

module radical_inverse_sequence #(
  parameter int INDEX_BITS = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rdi_pkg::RADIX_W-1:0] radix,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rdi_pkg::SEQ_W-1:0]   seq_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rdi_pkg::FRAC_W-1:0]  fraction
);
  import rdi_pkg::*;

  // reversed value and base power stay below base * 2^INDEX_BITS
  localparam int PW    = INDEX_BITS + RADIX_W - 1;
  localparam int CMAX  = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
  localparam int CW    = $clog2(CMAX);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_ACC, S_QUO, S_FIN} state_t;

  state_t                  state;
  logic [RADIX_W-1:0]      base;
  logic [INDEX_BITS-1:0]   n;       // dividend shifting out, quotient shifting in
  logic [DIGIT_W-1:0]      rem;
  logic [PW-1:0]           r;
  logic [PW-1:0]           p;
  logic [FRAC_BITS-1:0]    q;
  logic [CW-1:0]           cnt;

  logic [INDEX_BITS-1:0]   idx_in;
  logic [RADIX_W-1:0]      drem;
  logic                    dge;
  logic [DIGIT_W-1:0]      rem_next;
  logic [PW+RADIX_W-1:0]   r_prod;
  logic [PW+RADIX_W-1:0]   p_prod;
  logic [PW:0]             rs;
  logic [PW:0]             rdiff;
  logic                    qge;
  logic [PW-1:0]           r_next;
  logic                    last_div;
  logic                    last_quo;

  assign idx_in    = INDEX_BITS'(seq_index);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // one restoring step of index / base
  assign drem     = {rem, n[INDEX_BITS-1]};
  assign dge      = (drem >= base);
  assign rem_next = dge ? DIGIT_W'(drem - base) : drem[DIGIT_W-1:0];

  assign r_prod = {{RADIX_W{1'b0}}, r} * {{PW{1'b0}}, base};
  assign p_prod = {{RADIX_W{1'b0}}, p} * {{PW{1'b0}}, base};

  // one restoring step of r * 2^FRAC_BITS / p
  assign rs     = {r, 1'b0};
  assign rdiff  = rs - {1'b0, p};
  assign qge    = (rs >= {1'b0, p});
  assign r_next = qge ? rdiff[PW-1:0] : rs[PW-1:0];

  assign last_div = (cnt == CW'(INDEX_BITS - 1));
  assign last_quo = (cnt == CW'(FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      base      <= RADIX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= clamp_radix(radix);
      end
      // in S_FIN the output register is handled below
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= idx_in;
            r     <= '0;
            p     <= PW'(1);
            q     <= '0;
            rem   <= '0;
            cnt   <= '0;
            state <= (idx_in == '0) ? S_QUO : S_DIV;
          end
        end
        S_DIV: begin
          n   <= {n[INDEX_BITS-2:0], dge};
          rem <= rem_next;
          cnt <= cnt + CW'(1);
          if (last_div) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // append the digit just split off, scale the base power
          r     <= r_prod[PW-1:0] + PW'(rem);
          p     <= p_prod[PW-1:0];
          rem   <= '0;
          cnt   <= '0;
          state <= (n == '0) ? S_QUO : S_DIV;
        end
        S_QUO: begin
          r   <= r_next;
          q   <= {q[FRAC_BITS-2:0], qge};
          cnt <= cnt + CW'(1);
          if (last_quo) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            fraction  <= FRAC_W'(q);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RIS_ASSERT_IMPL(a_frac_below_one, state == S_QUO, r < p, "partial remainder reached the base power")
  `RIS_ASSERT_IMPL(a_digit_below_base, state == S_DIV, {1'b0, rem} < base, "digit remainder not below base")
  `RIS_ASSERT_NEXT(a_fin_holds, state == S_FIN && out_valid && !out_ready, state == S_FIN, "result left before output register freed")

endmodule
